// File: hdl/dvrt_pkg.sv
// shared types, codes and constants for the route table core
package dvrt_pkg;

    localparam int IDX_W     = 4;
    localparam int COST_W    = 16;
    localparam int CNT_W     = 5;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int MODE_W    = 3;
    localparam int NODES_DEF = 16;
    localparam int NODES_MAX = 16;

    localparam logic [CNT_W-1:0]  RST_COUNT  = CNT_W'(2);
    localparam logic [COST_W-1:0] RST_INF    = COST_W'(16);
    localparam logic [COST_W-1:0] RST_RELOAD = COST_W'(90);
    localparam logic [COST_W-1:0] RST_TICK   = COST_W'(30);

    localparam logic [MODE_W-1:0] MODE_INIT   = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_ADVERT = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_TICK   = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_BUILD  = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_READ   = MODE_W'(4);

    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NBR_MASK   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_INF_COST   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TTL_RELOAD = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_TICK_PER   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT      = CFG_IDX_W'(5);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT_REGS,
        OP_INIT_MEM,
        OP_ADV_ENTRY,
        OP_TTL_REF,
        OP_ADOPT,
        OP_AGE,
        OP_RELAX,
        OP_TICK_FIN,
        OP_ADV_ELEM,
        OP_ADV_END,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_ENT_WAIT,
        S_TTLREF,
        S_ADOPT,
        S_AGE,
        S_RELAX,
        S_FIN,
        S_INIT_MEM,
        S_BUILD,
        S_BEND,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  from_node;
        logic [IDX_W-1:0]  dest_node;
        logic [COST_W-1:0] adv_cost;
        logic              last_entry;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]  out_dest;
        logic [COST_W-1:0] out_cost;
        logic [IDX_W-1:0]  out_next_hop;
        logic [COST_W-1:0] out_ttl;
        logic              entry_valid;
        logic              accepted;
        logic              send_advert;
        logic              last_result;
    } t_out;

    typedef struct packed {
        logic             accept;
        t_op              op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             row_f;
        logic             col_d;
    } t_cmd;

    typedef struct packed {
        logic             acc;
        logic             few;
        logic             in_last;
        logic             out_free;
        logic [IDX_W-1:0] last_ix;
    } t_sta;

endpackage

// File: hdl/dvrt_ctrl.sv
// sequencer: walks node indices and issues one datapath operation per cycle, holding while the output side is busy
module dvrt_ctrl import dvrt_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [MODE_W-1:0] i_mode,
    output logic              o_in_ready,
    input  t_sta              i_sta,
    output t_cmd              o_cmd
);

    localparam int NUSE = (NODES > NODES_MAX) ? NODES_MAX : NODES;
    localparam int IW   = (NUSE > 1) ? $clog2(NUSE) : 1;
    localparam logic [IW-1:0] IX_ONE = IW'(1);

    t_state            r_state, n_state;
    logic [MODE_W-1:0] r_mode;
    logic [IW-1:0]     r_row, n_row;
    logic [IW-1:0]     r_col, n_col;
    logic              accept, col_end, row_end;

    assign accept  = (r_state == S_IDLE) && i_in_valid;
    assign col_end = (r_col == i_sta.last_ix[IW-1:0]);
    assign row_end = (r_row == i_sta.last_ix[IW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_mode  <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            if (accept) begin
                r_mode <= i_mode;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_row = IX_ONE;
                n_col = IX_ONE;
                case (r_mode)
                    MODE_INIT:   n_state = i_sta.few ? S_EMIT : S_INIT_MEM;
                    MODE_ADVERT: n_state = i_sta.acc ? S_ENT_WAIT : S_EMIT;
                    MODE_TICK:   n_state = i_sta.few ? S_EMIT : S_AGE;
                    MODE_BUILD:  n_state = i_sta.few ? S_BEND : S_BUILD;
                    default:     n_state = S_EMIT;
                endcase
            end
            S_ENT_WAIT: begin
                n_state = (i_sta.in_last && !i_sta.few) ? S_TTLREF : S_EMIT;
            end
            S_TTLREF: begin
                if (col_end) begin
                    n_state = S_ADOPT;
                    n_col   = IX_ONE;
                end else begin
                    n_col = r_col + IX_ONE;
                end
            end
            S_ADOPT: begin
                if (col_end) begin
                    n_state = S_EMIT;
                end else begin
                    n_col = r_col + IX_ONE;
                end
            end
            S_AGE: begin
                if (col_end) begin
                    n_state = S_RELAX;
                    n_row   = IX_ONE;
                    n_col   = IX_ONE;
                end else begin
                    n_col = r_col + IX_ONE;
                end
            end
            S_RELAX, S_INIT_MEM: begin
                if (col_end) begin
                    n_col = IX_ONE;
                    if (row_end) begin
                        n_state = (r_state == S_RELAX) ? S_FIN : S_EMIT;
                    end else begin
                        n_row = r_row + IX_ONE;
                    end
                end else begin
                    n_col = r_col + IX_ONE;
                end
            end
            S_FIN: begin
                if (col_end) begin
                    n_state = S_EMIT;
                end else begin
                    n_col = r_col + IX_ONE;
                end
            end
            S_BUILD: begin
                if (i_sta.out_free) begin
                    if (col_end) begin
                        n_state = S_BEND;
                    end else begin
                        n_col = r_col + IX_ONE;
                    end
                end
            end
            S_BEND, S_EMIT: begin
                if (i_sta.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_cmd.accept = accept;
        o_cmd.op     = OP_NONE;
        o_cmd.row    = IDX_W'(r_row);
        o_cmd.col    = IDX_W'(r_col);
        o_cmd.row_f  = 1'b0;
        o_cmd.col_d  = 1'b0;
        case (r_state)
            S_START: begin
                if (r_mode == MODE_INIT) begin
                    o_cmd.op = OP_INIT_REGS;
                end else if ((r_mode == MODE_ADVERT) && i_sta.acc) begin
                    o_cmd.op    = OP_ADV_ENTRY;
                    o_cmd.row_f = 1'b1;
                    o_cmd.col_d = 1'b1;
                end
            end
            S_TTLREF: begin
                o_cmd.op    = OP_TTL_REF;
                o_cmd.row_f = 1'b1;
            end
            S_ADOPT: begin
                o_cmd.op    = OP_ADOPT;
                o_cmd.row_f = 1'b1;
            end
            S_AGE:      o_cmd.op = OP_AGE;
            S_RELAX:    o_cmd.op = OP_RELAX;
            S_FIN:      o_cmd.op = OP_TICK_FIN;
            S_INIT_MEM: o_cmd.op = OP_INIT_MEM;
            S_BUILD: begin
                if (i_sta.out_free) begin
                    o_cmd.op = OP_ADV_ELEM;
                end
            end
            S_BEND: begin
                if (i_sta.out_free) begin
                    o_cmd.op = OP_ADV_END;
                end
            end
            S_EMIT: begin
                if (i_sta.out_free) begin
                    o_cmd.op = OP_EMIT;
                end
            end
            default: begin
                o_cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

// File: hdl/dvrt_dpath.sv
// datapath: settings, route table, cost matrix memory and output word register
module dvrt_dpath import dvrt_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_in                  i_in_word,
    input  t_cmd                 i_cmd,
    output t_sta                 o_sta,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_word
);

    localparam int NUSE = (NODES > NODES_MAX) ? NODES_MAX : NODES;
    localparam int IW   = (NUSE > 1) ? $clog2(NUSE) : 1;
    localparam int AW   = 2 * IW;
    localparam int MD   = 1 << AW;

    function automatic logic is_nbr(input logic [IDX_W-1:0] i, input logic [CNT_W-1:0] n,
                                    input logic [CFG_W-1:0] mask);
        return (i != '0) && ({1'b0, i} < n) && mask[i];
    endfunction

    // settings
    logic [CNT_W-1:0]  r_node_count;
    logic [CFG_W-1:0]  r_mask;
    logic [COST_W-1:0] r_inf, r_reload, r_tick;
    logic              r_split;

    t_in               r_in;

    // route table and row 0 of the cost matrix
    logic [COST_W-1:0] r_row0  [NUSE];
    logic [COST_W-1:0] r_rcost [NUSE];
    logic [IW-1:0]     r_rnh   [NUSE];
    logic [COST_W-1:0] r_rttl  [NUSE];
    logic [COST_W-1:0] r_oldc  [NUSE];
    logic [IW-1:0]     r_from  [NUSE];

    // neighbour rows of the cost matrix
    logic [COST_W-1:0] r_mem [MD];
    logic [MD-1:0]     r_mvld;
    logic [COST_W-1:0] r_rd_mem;
    logic              r_rd_vld, r_rd_diag;

    t_op               r_p_op;
    logic [IW-1:0]     r_p_row, r_p_col;

    logic              r_row_changed, r_send, r_pend_vld, r_out_vld;
    t_out              r_pend, r_out;

    logic [CNT_W-1:0]  wc;
    logic [IDX_W-1:0]  f, d, pi4, pr4;
    logic [IW-1:0]     fi, di, arow, acol, rix, oix;
    logic [AW-1:0]     raddr, waddr;
    logic [COST_W-1:0] rdata, cur_row0, cur_cost, cur_ttl, cur_old, dec, mem_wdata;
    logic [IW-1:0]     cur_nh;
    logic [COST_W:0]   sum_relax, sum_adopt;
    logic              nbr_f, nbr_i, nbr_r, omit, entry_upd, adopt_ok, relax_ok, age_exp;
    logic              mem_we, emitting;
    logic              nbr_vec [NUSE];
    t_out              row_word, emit_word, pend_last, empty_word;

    always_comb begin
        wc  = (r_node_count > CNT_W'(NUSE)) ? CNT_W'(NUSE) : r_node_count;
        f   = r_in.from_node;
        d   = r_in.dest_node;
        fi  = f[IW-1:0];
        di  = d[IW-1:0];
        pi4 = IDX_W'(r_p_col);
        pr4 = IDX_W'(r_p_row);

        arow  = i_cmd.row_f ? fi : i_cmd.row[IW-1:0];
        acol  = i_cmd.col_d ? di : i_cmd.col[IW-1:0];
        raddr = {arow, acol};
        waddr = {r_p_row, r_p_col};
        rdata = r_rd_vld ? r_rd_mem : (r_rd_diag ? '0 : RST_INF);

        rix      = (r_p_op == OP_EMIT) ? di : r_p_col;
        oix      = (r_p_op == OP_RELAX) ? r_p_row : r_p_col;
        cur_row0 = r_row0[r_p_col];
        cur_cost = r_rcost[rix];
        cur_nh   = r_rnh[rix];
        cur_ttl  = r_rttl[rix];
        cur_old  = r_oldc[oix];

        nbr_f = is_nbr(f, wc, r_mask);
        nbr_i = is_nbr(pi4, wc, r_mask);
        nbr_r = is_nbr(pr4, wc, r_mask);
        for (int j = 0; j < NUSE; j++) begin
            nbr_vec[j] = is_nbr(IDX_W'(j), wc, r_mask);
        end

        sum_relax = {1'b0, rdata} + {1'b0, cur_old};
        sum_adopt = {1'b0, rdata} + (COST_W+1)'(1);
        dec       = (cur_ttl > r_tick) ? (cur_ttl - r_tick) : '0;
        age_exp   = (cur_ttl != '0) && (dec == '0);
        relax_ok  = nbr_r && (pi4 != pr4) && !nbr_i && (sum_relax < {1'b0, cur_row0});
        adopt_ok  = r_row_changed && (pi4 != f) && (sum_adopt < {1'b0, cur_row0})
                    && (sum_adopt < {1'b0, r_inf});
        entry_upd = (d != '0) && ({1'b0, d} < wc) && (rdata != r_in.adv_cost);
        omit      = r_split && (f != '0) && (IDX_W'(cur_nh) == f);

        mem_we    = (r_p_op == OP_INIT_MEM) || ((r_p_op == OP_ADV_ENTRY) && entry_upd);
        mem_wdata = (r_p_op == OP_INIT_MEM) ? ((r_p_row == r_p_col) ? '0 : r_inf)
                                            : r_in.adv_cost;

        emitting = (r_p_op == OP_EMIT) || (r_p_op == OP_ADV_ELEM) || (r_p_op == OP_ADV_END);

        row_word              = '0;
        row_word.out_dest     = IDX_W'(rix);
        row_word.out_cost     = cur_cost;
        row_word.out_next_hop = IDX_W'(cur_nh);
        row_word.out_ttl      = cur_ttl;
        row_word.entry_valid  = 1'b1;
        row_word.accepted     = 1'b1;

        empty_word             = '0;
        empty_word.accepted    = 1'b1;
        empty_word.last_result = 1'b1;

        pend_last             = r_pend;
        pend_last.last_result = 1'b1;

        emit_word             = '0;
        emit_word.last_result = 1'b1;
        case (r_in.mode)
            MODE_INIT: emit_word = empty_word;
            MODE_ADVERT: begin
                emit_word.accepted    = nbr_f;
                emit_word.send_advert = r_send;
            end
            MODE_TICK: begin
                emit_word             = empty_word;
                emit_word.send_advert = 1'b1;
            end
            MODE_READ: begin
                if ({1'b0, d} < wc) begin
                    emit_word             = row_word;
                    emit_word.last_result = 1'b1;
                end else begin
                    emit_word = empty_word;
                end
            end
            default: emit_word.accepted = 1'b0;
        endcase

        o_sta.acc      = nbr_f;
        o_sta.few      = (wc < CNT_W'(2));
        o_sta.in_last  = r_in.last_entry;
        o_sta.out_free = !r_out_vld && !emitting;
        o_sta.last_ix  = IDX_W'(wc - CNT_W'(1));

        o_out_valid = r_out_vld;
        o_out_word  = r_out;
    end

    // cost matrix memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= mem_wdata;
        end
        r_rd_mem  <= r_mem[raddr];
        r_rd_diag <= (arow == acol);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (mem_we) begin
                r_mvld[waddr] <= 1'b1;
            end
            r_rd_vld <= r_mvld[raddr];
        end
    end

    // route table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUSE; j++) begin
                r_row0[j]  <= (j == 0) ? '0 : RST_INF;
                r_rcost[j] <= (j == 0) ? '0 : RST_INF;
                r_rnh[j]   <= '0;
                r_rttl[j]  <= '0;
            end
        end else begin
            case (r_p_op)
                OP_INIT_REGS: begin
                    r_row0[0]  <= '0;
                    r_rcost[0] <= '0;
                    r_rnh[0]   <= '0;
                    r_rttl[0]  <= r_reload;
                    for (int j = 1; j < NUSE; j++) begin
                        if (CNT_W'(j) < wc) begin
                            r_row0[j]  <= nbr_vec[j] ? COST_W'(1) : r_inf;
                            r_rcost[j] <= nbr_vec[j] ? COST_W'(1) : r_inf;
                            r_rnh[j]   <= nbr_vec[j] ? IW'(j) : '0;
                            r_rttl[j]  <= r_reload;
                        end
                    end
                end
                OP_ADV_ENTRY: begin
                    r_rttl[fi]  <= r_reload;
                    r_rcost[fi] <= COST_W'(1);
                    r_rnh[fi]   <= fi;
                    r_row0[fi]  <= COST_W'(1);
                end
                OP_TTL_REF: begin
                    if ((IDX_W'(cur_nh) == f) && (rdata != r_inf)) begin
                        r_rttl[r_p_col] <= r_reload;
                    end
                end
                OP_ADOPT: begin
                    if (adopt_ok) begin
                        r_row0[r_p_col]  <= sum_adopt[COST_W-1:0];
                        r_rcost[r_p_col] <= sum_adopt[COST_W-1:0];
                        r_rttl[r_p_col]  <= r_reload;
                        r_rnh[r_p_col]   <= fi;
                    end
                end
                OP_AGE: begin
                    if (cur_ttl != '0) begin
                        r_rttl[r_p_col] <= dec;
                    end
                    if (age_exp) begin
                        r_rnh[r_p_col]   <= '0;
                        r_rcost[r_p_col] <= r_inf;
                    end
                    r_row0[r_p_col] <= r_inf;
                end
                OP_RELAX: begin
                    if (relax_ok) begin
                        r_row0[r_p_col] <= sum_relax[COST_W-1:0];
                    end
                end
                OP_TICK_FIN: begin
                    if (cur_old < cur_row0) begin
                        r_row0[r_p_col] <= cur_old;
                    end else if (!nbr_i) begin
                        r_rcost[r_p_col] <= cur_row0;
                        r_rttl[r_p_col]  <= r_reload;
                        r_rnh[r_p_col]   <= r_from[r_p_col];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // tick scratch
    always_ff @(posedge i_clk) begin
        case (r_p_op)
            OP_AGE: begin
                r_oldc[r_p_col] <= age_exp ? r_inf : cur_row0;
                r_from[r_p_col] <= '0;
            end
            OP_RELAX: begin
                if (relax_ok) begin
                    r_from[r_p_col] <= r_p_row;
                end
            end
            default: begin
            end
        endcase
    end

    // settings, flags and output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count  <= RST_COUNT;
            r_mask        <= '0;
            r_inf         <= RST_INF;
            r_reload      <= RST_RELOAD;
            r_tick        <= RST_TICK;
            r_split       <= 1'b0;
            r_p_op        <= OP_NONE;
            r_row_changed <= 1'b0;
            r_send        <= 1'b0;
            r_pend_vld    <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_NODE_COUNT: r_node_count <= i_cfg_data[CNT_W-1:0];
                    REG_NBR_MASK:   r_mask       <= i_cfg_data;
                    REG_INF_COST:   r_inf        <= i_cfg_data[COST_W-1:0];
                    REG_TTL_RELOAD: r_reload     <= i_cfg_data[COST_W-1:0];
                    REG_TICK_PER:   r_tick       <= i_cfg_data[COST_W-1:0];
                    REG_SPLIT:      r_split      <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            r_p_op <= i_cmd.op;
            if (i_cmd.accept) begin
                r_send     <= 1'b0;
                r_pend_vld <= 1'b0;
            end
            if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_p_op)
                OP_INIT_REGS: r_row_changed <= 1'b0;
                OP_ADV_ENTRY: begin
                    if (entry_upd) begin
                        r_row_changed <= 1'b1;
                    end
                end
                OP_ADOPT: begin
                    if (adopt_ok) begin
                        r_send <= 1'b1;
                    end
                end
                OP_ADV_ELEM: begin
                    if (!omit) begin
                        if (r_pend_vld) begin
                            r_out_vld <= 1'b1;
                        end
                        r_pend_vld <= 1'b1;
                    end
                end
                OP_ADV_END: begin
                    r_out_vld  <= 1'b1;
                    r_pend_vld <= 1'b0;
                end
                OP_EMIT: begin
                    r_out_vld <= 1'b1;
                    if ((r_in.mode == MODE_ADVERT) && r_in.last_entry) begin
                        r_row_changed <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_in_word;
        end
        r_p_row <= arow;
        r_p_col <= acol;
        case (r_p_op)
            OP_ADV_ELEM: begin
                if (!omit) begin
                    if (r_pend_vld) begin
                        r_out <= r_pend;
                    end
                    r_pend <= row_word;
                end
            end
            OP_ADV_END: r_out <= r_pend_vld ? pend_last : empty_word;
            OP_EMIT:    r_out <= emit_word;
            default: begin
            end
        endcase
    end

endmodule

// File: hdl/distance_vector_route_table_core.sv
// top level of the route table core
//
//  channel   direction  handshake                       word
//  in        input      i_in_valid / o_in_ready         i_in_word (t_in)
//  out       output     o_out_valid / i_out_ready       o_out_word (t_out)
//  config    input      i_cfg_we, i_cfg_idx             i_cfg_data
//
// one word in flight at a time; n is the node count in use, a sequencer walks
// indices 1..n-1 at one operation per cycle through a one-stage datapath
// init sweeps the cost matrix rows; tick ages the routes, relaxes over the matrix
// and finishes; an advert entry refreshes and adopts routes only on the last entry,
// build advert walks the routes and read route looks up one; each of them waits
// while the out side stalls
// the cost matrix reads through per-entry valid bits, so no clearing pass
// after reset; a finished word waits in the output register while a new word
// is taken in
module distance_vector_route_table_core import dvrt_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_word,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd cmd;
    t_sta sta;

    dvrt_ctrl #(
        .NODES (NODES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_word.mode),
        .o_in_ready (o_in_ready),
        .i_sta      (sta),
        .o_cmd      (cmd)
    );

    dvrt_dpath #(
        .NODES (NODES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_sta       (sta),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
